FILE: rtl/core/pup_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pup_pkg - shared constants for the factoradic permutation unranker
// Field widths of the stream words and the ordered element list.
// ============================================================================
package pup_pkg;

    localparam int PUP_RANK_W       = 29;   // perm_rank field
    localparam int PUP_COUNT_W      = 4;    // count field
    localparam int PUP_PACK_W       = 48;   // perm_packed field
    localparam int PUP_NIB_W        = 4;    // one element / one digit
    localparam int PUP_LIST_NIBS    = 16;   // nibbles in the ordered list
    localparam int PUP_LIST_W       = PUP_LIST_NIBS * PUP_NIB_W;
    localparam int PUP_IN_TDATA_W   = 40;   // 33 payload bits, byte padded
    localparam int PUP_OUT_TDATA_W  = 56;   // 49 payload bits, byte padded
    localparam int PUP_MAX_ELEM_DEF = 12;

    localparam logic [PUP_LIST_W-1:0] PUP_ORDERED_LIST = 64'hFEDC_BA98_7654_3210;

endpackage : pup_pkg
`default_nettype wire

FILE: rtl/core/pup_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pup_div_cell - one factorial-base digit cell
// Divides the running rank by the constant K over two register stages and
// drops the remainder into digit slot K; folds its low bit into the parity if K <= count.
// ============================================================================
module pup_div_cell
    import pup_pkg::*;
#(
    parameter int K     = 2,
    parameter int CNT_W = 4,
    parameter int NDIG  = 13
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [PUP_RANK_W-1:0]         i_rank,
    input  wire logic [CNT_W-1:0]              i_count,
    input  wire logic [NDIG*PUP_NIB_W-1:0]     i_digits,
    input  wire logic                          i_parity,
    output logic                               o_valid,
    output logic      [PUP_RANK_W-1:0]         o_rank,
    output logic      [CNT_W-1:0]              o_count,
    output logic      [NDIG*PUP_NIB_W-1:0]     o_digits,
    output logic                               o_parity
);

    // exact reciprocal for any rank below 2**PUP_RANK_W
    localparam int SHIFT   = PUP_RANK_W + $clog2(K);
    localparam int RECIP_W = PUP_RANK_W + 1;
    localparam int PROD_W  = PUP_RANK_W + RECIP_W;
    localparam int LOW_W   = PUP_NIB_W + 1;
    localparam longint unsigned RECIP_FULL = ((64'd1 << SHIFT) + K - 1) / K;
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_FULL);

    logic [PROD_W-1:0]              w_prod;
    logic [PUP_RANK_W-1:0]          w_quot;

    logic                           r_a_valid;
    logic [PUP_RANK_W-1:0]          r_a_quot;
    logic [LOW_W-1:0]               r_a_low;
    logic [CNT_W-1:0]               r_a_count;
    logic [NDIG*PUP_NIB_W-1:0]      r_a_digits;
    logic                           r_a_parity;

    logic [LOW_W-1:0]               w_qk_low;
    logic [LOW_W-1:0]               w_rem;
    logic [NDIG*PUP_NIB_W-1:0]      n_digits;
    logic                           n_parity;

    logic                           r_b_valid;
    logic [PUP_RANK_W-1:0]          r_b_rank;
    logic [CNT_W-1:0]               r_b_count;
    logic [NDIG*PUP_NIB_W-1:0]      r_b_digits;
    logic                           r_b_parity;

    assign w_prod = PROD_W'(i_rank) * PROD_W'(RECIP);
    assign w_quot = PUP_RANK_W'(w_prod >> SHIFT);

    // stage A: quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_quot   <= w_quot;
            r_a_low    <= i_rank[LOW_W-1:0];
            r_a_count  <= i_count;
            r_a_digits <= i_digits;
            r_a_parity <= i_parity;
        end
    end

    // remainder is below 16, so the low bits of rank - q*K are exact
    assign w_qk_low = LOW_W'(r_a_quot[LOW_W-1:0] * LOW_W'(K));
    assign w_rem    = LOW_W'(r_a_low - w_qk_low);

    always_comb begin
        n_digits = r_a_digits;
        n_digits[K*PUP_NIB_W +: PUP_NIB_W] = w_rem[PUP_NIB_W-1:0];
        n_parity = r_a_parity ^ (w_rem[0] & (r_a_count >= CNT_W'(K)));
    end

    // stage B: digit and parity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_rank   <= r_a_quot;
            r_b_count  <= r_a_count;
            r_b_digits <= n_digits;
            r_b_parity <= n_parity;
        end
    end

    assign o_valid  = r_b_valid;
    assign o_rank   = r_b_rank;
    assign o_count  = r_b_count;
    assign o_digits = r_b_digits;
    assign o_parity = r_b_parity;

endmodule : pup_div_cell
`default_nettype wire

FILE: rtl/core/pup_sel_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pup_sel_cell - one element selection cell
// Fills output position J: picks the element at the digit's position out of
// the remaining list and removes it, or places the last element left.
// ============================================================================
module pup_sel_cell
    import pup_pkg::*;
#(
    parameter int J     = 0,
    parameter int CNT_W = 4,
    parameter int NDIG  = 13,
    parameter int MAXN  = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [CNT_W-1:0]              i_count,
    input  wire logic [NDIG*PUP_NIB_W-1:0]     i_digits,
    input  wire logic [PUP_LIST_W-1:0]         i_list,
    input  wire logic [MAXN*PUP_NIB_W-1:0]     i_result,
    input  wire logic                          i_parity,
    output logic                               o_valid,
    output logic      [CNT_W-1:0]              o_count,
    output logic      [NDIG*PUP_NIB_W-1:0]     o_digits,
    output logic      [PUP_LIST_W-1:0]         o_list,
    output logic      [MAXN*PUP_NIB_W-1:0]     o_result,
    output logic                               o_parity
);

    logic                           w_pick;
    logic                           w_last;
    logic [CNT_W-1:0]               w_idx;
    logic [PUP_NIB_W-1:0]           w_shift;
    logic [PUP_NIB_W-1:0]           w_elem;
    logic [PUP_LIST_W-1:0]          n_list;
    logic [MAXN*PUP_NIB_W-1:0]      n_result;

    logic                           r_valid;
    logic [CNT_W-1:0]               r_count;
    logic [NDIG*PUP_NIB_W-1:0]      r_digits;
    logic [PUP_LIST_W-1:0]          r_list;
    logic [MAXN*PUP_NIB_W-1:0]      r_result;
    logic                           r_parity;

    assign w_pick = CNT_W'(J + 1) < i_count;
    assign w_last = CNT_W'(J + 1) == i_count;
    // position J uses digit n-J, most significant first
    assign w_idx  = CNT_W'(i_count - CNT_W'(J));

    always_comb begin
        w_shift = '0;
        for (int e = 0; e < NDIG; e++) begin
            if (w_pick && w_idx == CNT_W'(e)) begin
                w_shift = i_digits[e*PUP_NIB_W +: PUP_NIB_W];
            end
        end
        w_elem = i_list[w_shift*PUP_NIB_W +: PUP_NIB_W];

        // close the gap left by the picked element
        for (int i = 0; i < PUP_LIST_NIBS; i++) begin
            if (!w_pick || i < int'(w_shift)) begin
                n_list[i*PUP_NIB_W +: PUP_NIB_W] = i_list[i*PUP_NIB_W +: PUP_NIB_W];
            end else if (i == PUP_LIST_NIBS - 1) begin
                n_list[i*PUP_NIB_W +: PUP_NIB_W] = '0;
            end else begin
                n_list[i*PUP_NIB_W +: PUP_NIB_W] = i_list[(i+1)*PUP_NIB_W +: PUP_NIB_W];
            end
        end

        n_result = i_result;
        if (w_pick) begin
            n_result[J*PUP_NIB_W +: PUP_NIB_W] = w_elem;
        end else if (w_last) begin
            n_result[J*PUP_NIB_W +: PUP_NIB_W] = i_list[PUP_NIB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_count  <= i_count;
            r_digits <= i_digits;
            r_list   <= n_list;
            r_result <= n_result;
            r_parity <= i_parity;
        end
    end

    assign o_valid  = r_valid;
    assign o_count  = r_count;
    assign o_digits = r_digits;
    assign o_list   = r_list;
    assign o_result = r_result;
    assign o_parity = r_parity;

endmodule : pup_sel_cell
`default_nettype wire

FILE: rtl/core/permutation_unrank_factoradic_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// permutation_unrank_factoradic_top - factoradic permutation unranker
// Splits each rank into factorial-base digits in a row of divide cells, then
// builds the permutation one position per cell in a row of select cells.
// ============================================================================
//  channel   dir  width  word layout (lsb first)
//  s_axis    in   40     perm_rank[28:0], count[32:29], zero pad
//  m_axis    out  56     perm_packed[47:0], rank_parity[48], zero pad
//
//  One word accepted per cycle while the output is not stalled, one result word per input word.
//  Pipeline: an input register, two stages per divide cell (multiply,
//  remainder), one stage per select cell; the last select register is the
//  output register.
//  Reset clears only the valid bits; it takes effect on the next clock.
//  A stalled output word holds the whole pipeline; s_axis_tready drops with it.
// ============================================================================
module permutation_unrank_factoradic_top
    import pup_pkg::*;
#(
    parameter int MAX_ELEMENTS = PUP_MAX_ELEM_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [PUP_IN_TDATA_W-1:0]   s_axis_tdata,  // perm_rank, count
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [PUP_OUT_TDATA_W-1:0]  m_axis_tdata   // perm_packed, rank_parity
);

    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int NDIG   = MAX_ELEMENTS + 1;
    localparam int DIG_W  = NDIG * PUP_NIB_W;
    localparam int RES_W  = MAX_ELEMENTS * PUP_NIB_W;
    localparam int CMP_W  = CNT_W + PUP_COUNT_W;

    logic                       w_en;
    logic [PUP_RANK_W-1:0]      w_in_rank;
    logic [PUP_COUNT_W-1:0]     w_in_count;
    logic [CNT_W-1:0]           n_count;

    logic                       r_in_valid;
    logic [PUP_RANK_W-1:0]      r_in_rank;
    logic [CNT_W-1:0]           r_in_count;

    logic                       w_dv_valid  [MAX_ELEMENTS];
    logic [PUP_RANK_W-1:0]      w_dv_rank   [MAX_ELEMENTS];
    logic [CNT_W-1:0]           w_dv_count  [MAX_ELEMENTS];
    logic [DIG_W-1:0]           w_dv_digits [MAX_ELEMENTS];
    logic                       w_dv_parity [MAX_ELEMENTS];

    logic                       w_sl_valid  [MAX_ELEMENTS+1];
    logic [CNT_W-1:0]           w_sl_count  [MAX_ELEMENTS+1];
    logic [DIG_W-1:0]           w_sl_digits [MAX_ELEMENTS+1];
    logic [PUP_LIST_W-1:0]      w_sl_list   [MAX_ELEMENTS+1];
    logic [RES_W-1:0]           w_sl_result [MAX_ELEMENTS+1];
    logic                       w_sl_parity [MAX_ELEMENTS+1];

    logic [63:0]                w_wide;

    // advance everything unless a finished word is waiting
    assign w_en          = !w_sl_valid[MAX_ELEMENTS] || m_axis_tready;
    assign s_axis_tready = w_en;

    assign w_in_rank  = s_axis_tdata[PUP_RANK_W-1:0];
    assign w_in_count = s_axis_tdata[PUP_RANK_W +: PUP_COUNT_W];

    // saturate count at the largest supported n
    assign n_count = (CMP_W'(w_in_count) > CMP_W'(MAX_ELEMENTS))
                   ? CNT_W'(MAX_ELEMENTS) : CNT_W'(w_in_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_rank  <= w_in_rank;
            r_in_count <= n_count;
        end
    end

    assign w_dv_valid[0]  = r_in_valid;
    assign w_dv_rank[0]   = r_in_rank;
    assign w_dv_count[0]  = r_in_count;
    assign w_dv_digits[0] = '0;
    assign w_dv_parity[0] = 1'b0;

    for (genvar m = 1; m < MAX_ELEMENTS; m++) begin : g_div
        pup_div_cell #(
            .K     (m + 1),
            .CNT_W (CNT_W),
            .NDIG  (NDIG)
        ) u_div (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (w_dv_valid[m-1]),
            .i_rank   (w_dv_rank[m-1]),
            .i_count  (w_dv_count[m-1]),
            .i_digits (w_dv_digits[m-1]),
            .i_parity (w_dv_parity[m-1]),
            .o_valid  (w_dv_valid[m]),
            .o_rank   (w_dv_rank[m]),
            .o_count  (w_dv_count[m]),
            .o_digits (w_dv_digits[m]),
            .o_parity (w_dv_parity[m])
        );
    end

    assign w_sl_valid[0]  = w_dv_valid[MAX_ELEMENTS-1];
    assign w_sl_count[0]  = w_dv_count[MAX_ELEMENTS-1];
    assign w_sl_digits[0] = w_dv_digits[MAX_ELEMENTS-1];
    assign w_sl_list[0]   = PUP_ORDERED_LIST;
    assign w_sl_result[0] = '0;
    assign w_sl_parity[0] = w_dv_parity[MAX_ELEMENTS-1];

    for (genvar j = 0; j < MAX_ELEMENTS; j++) begin : g_sel
        pup_sel_cell #(
            .J     (j),
            .CNT_W (CNT_W),
            .NDIG  (NDIG),
            .MAXN  (MAX_ELEMENTS)
        ) u_sel (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (w_sl_valid[j]),
            .i_count  (w_sl_count[j]),
            .i_digits (w_sl_digits[j]),
            .i_list   (w_sl_list[j]),
            .i_result (w_sl_result[j]),
            .i_parity (w_sl_parity[j]),
            .o_valid  (w_sl_valid[j+1]),
            .o_count  (w_sl_count[j+1]),
            .o_digits (w_sl_digits[j+1]),
            .o_list   (w_sl_list[j+1]),
            .o_result (w_sl_result[j+1]),
            .o_parity (w_sl_parity[j+1])
        );
    end

    // drop nibbles beyond the 48-bit field
    assign w_wide = 64'(w_sl_result[MAX_ELEMENTS]);

    assign m_axis_tvalid = w_sl_valid[MAX_ELEMENTS];
    assign m_axis_tdata  = {
        (PUP_OUT_TDATA_W - PUP_PACK_W - 1)'(0),
        w_sl_parity[MAX_ELEMENTS],
        w_wide[PUP_PACK_W-1:0]
    };

endmodule : permutation_unrank_factoradic_top
`default_nettype wire

FILE: test/permutation_unrank_factoradic_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// permutation_unrank_factoradic_top_tb - unranker stream testbench
// Streams rank/count words through the unranker, predicts each permutation
// and its parity in a behavioral model, and checks every result word in order
// under random stalls on both sides and one long output hold-off.
// ============================================================================
module permutation_unrank_factoradic_top_tb;
    import pup_pkg::*;

    localparam int MAX_ELEM   = PUP_MAX_ELEM_DEF;
    localparam int RAND_ITEMS = 1500;
    localparam int IDLE_PCT   = 9;
    localparam int HOLD_START = 300;    // result words seen before the hold-off
    localparam int HOLD_LEN   = 200;    // cycles of hold-off
    localparam int CALM_LO    = 800;    // word window with no idling
    localparam int CALM_HI    = 1100;
    localparam int DRAIN_CYC  = 60;

    typedef struct {
        logic [PUP_RANK_W-1:0]  rank;
        logic [PUP_COUNT_W-1:0] cnt;
    } t_rank_req;

    typedef struct {
        logic [PUP_PACK_W-1:0] perm;
        logic                  par;
    } t_perm_res;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [PUP_IN_TDATA_W-1:0]  s_axis_tdata = '0;   // perm_rank, count
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [PUP_OUT_TDATA_W-1:0] m_axis_tdata;        // perm_packed, rank_parity

    t_rank_req rank_req_q[$];
    t_perm_res perm_exp_q[$];

    int   err_cnt = 0;
    int   sent_cnt = 0;
    int   recv_cnt = 0;
    logic in_taken = 1'b0;
    logic hold_off = 1'b0;

    permutation_unrank_factoradic_top #(
        .MAX_ELEMENTS(MAX_ELEM)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Behavioral unranker: factorial digits, then pick-and-remove from 0..n-1.
    function automatic t_perm_res unrank_predict(input logic [PUP_RANK_W-1:0] rank,
                                                 input logic [PUP_COUNT_W-1:0] cnt);
        t_perm_res res;
        int        n;
        int        shift;
        int        sum;
        int        digit [0:MAX_ELEM];
        logic [31:0]         r;
        logic [PUP_LIST_W-1:0] lst;
        logic [PUP_LIST_W-1:0] low;
        logic [PUP_LIST_W-1:0] acc;
        logic [PUP_LIST_W-1:0] elem;
        n   = (cnt > MAX_ELEM) ? MAX_ELEM : int'(cnt);
        r   = 32'(rank);
        sum = 0;
        acc = '0;
        lst = PUP_ORDERED_LIST;
        for (int k = 0; k <= MAX_ELEM; k++)
            digit[k] = 0;
        if (n >= 1) begin
            for (int k = 2; k <= n; k++) begin
                digit[k] = int'(r % k);
                r        = r / k;
                sum     += digit[k];
            end
            for (int k = 0; k + 1 < n; k++) begin
                shift = (digit[n - k] & 4'hF) * PUP_NIB_W;
                elem  = (lst >> shift) & 64'hF;
                low   = (64'd1 << shift) - 64'd1;
                acc   = acc | (elem << (PUP_NIB_W * k));
                lst   = (lst & low) | ((lst >> PUP_NIB_W) & ~low);
            end
            acc = acc | ((lst & 64'hF) << (PUP_NIB_W * (n - 1)));
        end
        res.perm = acc[PUP_PACK_W-1:0];
        res.par  = (n >= 1) ? sum[0] : 1'b0;
        return res;
    endfunction

    // Both handshakes are observed here, at the rising edge.
    always @(posedge i_clk) begin
        t_perm_res exp_res;
        t_perm_res got;
        if (i_rst_n) begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                perm_exp_q.push_back(unrank_predict(s_axis_tdata[PUP_RANK_W-1:0],
                    s_axis_tdata[PUP_RANK_W +: PUP_COUNT_W]));
            if (m_axis_tvalid && m_axis_tready) begin
                recv_cnt <= recv_cnt + 1;
                got.perm = m_axis_tdata[PUP_PACK_W-1:0];
                got.par  = m_axis_tdata[PUP_PACK_W];
                if (perm_exp_q.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    $display("%0t: unexpected result word, actual perm=%012h parity=%0b",
                             $time, got.perm, got.par);
                end else begin
                    exp_res = perm_exp_q.pop_front();
                    if (got.perm !== exp_res.perm) begin
                        err_cnt = err_cnt + 1;
                        $display("%0t: perm_packed mismatch, expected %012h actual %012h",
                                 $time, exp_res.perm, got.perm);
                    end
                    if (got.par !== exp_res.par) begin
                        err_cnt = err_cnt + 1;
                        $display("%0t: rank_parity mismatch, expected %0b actual %0b",
                                 $time, exp_res.par, got.par);
                    end
                end
            end
        end else begin
            in_taken <= 1'b0;
        end
    end

    // Sender: advance only after the current word was taken.
    always @(negedge i_clk) begin
        t_rank_req req;
        logic      calm;
        calm = (sent_cnt >= CALM_LO) && (sent_cnt < CALM_HI);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (!calm && $urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
            end else if (rank_req_q.size() != 0) begin
                req           = rank_req_q.pop_front();
                s_axis_tdata  <= {{(PUP_IN_TDATA_W-PUP_RANK_W-PUP_COUNT_W){1'b0}},
                                  req.cnt, req.rank};
                s_axis_tvalid <= 1'b1;
                sent_cnt      <= sent_cnt + 1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, none in the calm window; ready is held low during the hold-off.
    always @(negedge i_clk) begin
        logic calm;
        calm = (recv_cnt >= CALM_LO) && (recv_cnt < CALM_HI);
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Long output hold-off so the pipeline fills and stalls its input.
    initial begin
        wait (recv_cnt >= HOLD_START);
        @(negedge i_clk) hold_off <= 1'b1;
        repeat (HOLD_LEN) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic queue_rank(input logic [PUP_RANK_W-1:0] rank,
                              input logic [PUP_COUNT_W-1:0] cnt);
        t_rank_req req;
        req.rank = rank;
        req.cnt  = cnt;
        rank_req_q.push_back(req);
    endtask

    initial begin
        logic [3:0]  cnt;
        logic [31:0] fact;
        int          sel;

        // Directed: empty and single counts, extremes of rank, wrap at n!,
        // saturating counts.
        queue_rank(29'd0, 4'd0);
        queue_rank(29'h1FFF_FFFF, 4'd0);
        queue_rank(29'd5, 4'd1);
        queue_rank(29'h1FFF_FFFF, 4'd1);
        queue_rank(29'd0, 4'd2);
        queue_rank(29'd1, 4'd2);
        queue_rank(29'd2, 4'd2);
        queue_rank(29'd5, 4'd3);
        queue_rank(29'd6, 4'd3);
        queue_rank(29'd23, 4'd4);
        queue_rank(29'd119, 4'd5);
        queue_rank(29'd720, 4'd6);
        queue_rank(29'd5039, 4'd7);
        queue_rank(29'd0, 4'd12);
        queue_rank(29'd1, 4'd12);
        queue_rank(29'd479001599, 4'd12);
        queue_rank(29'd479001600, 4'd12);
        queue_rank(29'h1FFF_FFFF, 4'd12);
        queue_rank(29'h1555_5555, 4'd12);
        queue_rank(29'h0AAA_AAAA, 4'd11);
        queue_rank(29'd479001599, 4'd13);
        queue_rank(29'($urandom), 4'd14);
        queue_rank(29'h1FFF_FFFF, 4'd15);

        // Random: mostly in-range counts, ranks either below n! or anywhere.
        for (int i = 0; i < RAND_ITEMS; i++) begin
            sel = $urandom_range(99);
            if (sel < 4)
                cnt = 4'd0;
            else if (sel < 10)
                cnt = 4'($urandom_range(15, 13));
            else
                cnt = 4'($urandom_range(12, 1));
            fact = 32'd1;
            for (int k = 2; k <= ((cnt > MAX_ELEM) ? MAX_ELEM : cnt); k++)
                fact = fact * k;
            if ($urandom_range(99) < 60)
                queue_rank(29'($urandom % fact), cnt);
            else
                queue_rank(29'($urandom), cnt);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        wait (rank_req_q.size() == 0);
        @(posedge i_clk);
        while (s_axis_tvalid) @(posedge i_clk);
        wait (perm_exp_q.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_cnt == 0)
            $display("permutation_unrank_factoradic_top_tb: done, clean");
        else
            $display("permutation_unrank_factoradic_top_tb: done, errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("permutation_unrank_factoradic_top_tb: done, errors");
        $finish;
    end

endmodule : permutation_unrank_factoradic_top_tb
